### rtl/core/at_reply_ring_and_line_classifier_top_macros.svh
// assertion macros for the at reply ring and line classifier
// used by the top level only, no other dependencies
`ifndef AT_REPLY_RING_AND_LINE_CLASSIFIER_TOP_MACROS_SVH
`define AT_REPLY_RING_AND_LINE_CLASSIFIER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ARL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ARL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARL_ASSERT(lbl, prop, msg)
`define ARL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/core/arl_pkg.sv
// shared types, codes and match pattern tables for the at reply classifier
// no dependencies
package arl_pkg;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_POP  = 2'd1,
    OP_ARM  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_WAIT = 2'd0,
    ST_OK   = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic       rx;
    logic       arm;
    logic [7:0] data;
  } line_cmd_t;

  localparam int NUM_SUBS  = 7;
  localparam int NUM_EXACT = 3;
  localparam int SUB_MAX   = 16;
  localparam int EXACT_MAX = 8;
  localparam int PROG_W    = 4;

  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;

  localparam logic [SUB_MAX*8-1:0] SUB_TEXT [NUM_SUBS] = '{
    "WIFI CONNECTED", "WIFI DISCONNECT", "CONNECT", "CLOSED", "+IPD", "SEND OK", ">"
  };
  localparam int SUB_LEN [NUM_SUBS] = '{14, 15, 7, 6, 4, 7, 1};

  localparam logic [EXACT_MAX*8-1:0] EXACT_TEXT [NUM_EXACT] = '{"OK", "ERROR", "FAIL"};
  localparam int EXACT_LEN [NUM_EXACT] = '{2, 5, 4};

  // substring slot roles in the priority chain
  localparam int SUB_WIFI_CONN = 0;
  localparam int SUB_WIFI_DISC = 1;
  localparam int SUB_CONNECT   = 2;
  localparam int SUB_CLOSED    = 3;
  localparam int SUB_IPD       = 4;
  localparam int SUB_SEND_OK   = 5;
  localparam int SUB_PROMPT    = 6;
  localparam int EXACT_OK      = 0;

  function automatic logic [7:0] sub_char(input int i, input int j);
    logic [7:0] ch;
    ch = 8'h00;
    if (j < SUB_LEN[i]) ch = SUB_TEXT[i][(SUB_LEN[i]-1-j)*8 +: 8];
    return ch;
  endfunction

  function automatic logic [7:0] exact_char(input int i, input int j);
    logic [7:0] ch;
    ch = 8'h00;
    if (j < EXACT_LEN[i]) ch = EXACT_TEXT[i][(EXACT_LEN[i]-1-j)*8 +: 8];
    return ch;
  endfunction

  // prefix of length m is also a suffix of the prefix of length p
  function automatic logic border(input int i, input int p, input int m);
    logic ok;
    ok = 1'b1;
    for (int t = 0; t < m; t++) begin
      if (sub_char(i, t) != sub_char(i, p - m + t)) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

### rtl/core/arl_in_if.sv
// input channel: op code and received byte with valid/ready
// no dependencies
interface arl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

### rtl/core/arl_out_if.sv
// result channel: pop data, reply status and drop flag with valid/ready
// no dependencies
interface arl_out_if;
  logic       valid;
  logic       ready;
  logic       pop_valid;
  logic [7:0] pop_byte;
  logic [1:0] response;
  logic       byte_dropped;

  modport source (output valid, output pop_valid, output pop_byte, output response,
                  output byte_dropped, input ready);
  modport sink (input valid, input pop_valid, input pop_byte, input response,
                input byte_dropped, output ready);
endinterface

### rtl/core/arl_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module arl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### rtl/core/arl_line.sv
// line assembler with on-the-fly exact and substring matchers and reply status
// depends on arl_pkg
module arl_line #(
  parameter int LINE_LIMIT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  arl_pkg::line_cmd_t cmd,
  output arl_pkg::status_t   status_next
);
  import arl_pkg::*;

  localparam int LEN_W = $clog2(LINE_LIMIT);

  logic [LEN_W-1:0]  line_length;
  logic              zero_seen;
  logic [NUM_EXACT-1:0] alive;
  logic [PROG_W-1:0] prog [NUM_SUBS];
  logic [NUM_SUBS-1:0] found;
  status_t           status;

  logic                 is_eol;
  logic                 keep;
  logic                 feed;
  logic                 do_class;
  logic [NUM_EXACT-1:0] alive_next;
  logic [NUM_EXACT-1:0] alive_class;
  logic [PROG_W-1:0]    adv [NUM_SUBS];
  status_t              class_status;

  assign is_eol   = (cmd.data == CHAR_LF) || (cmd.data == CHAR_CR);
  assign keep     = cmd.rx && !is_eol && (line_length < LEN_W'(LINE_LIMIT - 1));
  assign feed     = keep && !zero_seen;
  assign do_class = cmd.rx && is_eol && (line_length != '0);

  always_comb begin
    for (int i = 0; i < NUM_EXACT; i++) begin
      if (cmd.data == 8'h00) begin
        alive_next[i] = alive[i] && (int'(line_length) == EXACT_LEN[i]);
      end else begin
        alive_next[i] = 1'b0;
        for (int j = 0; j < EXACT_MAX; j++) begin
          if ((int'(line_length) == j) && (j < EXACT_LEN[i]) &&
              (exact_char(i, j) == cmd.data)) alive_next[i] = alive[i];
        end
      end
      alive_class[i] = alive[i] && (zero_seen || (int'(line_length) == EXACT_LEN[i]));
    end
  end

  // kmp step: longest border of the current prefix that the byte extends
  always_comb begin
    for (int i = 0; i < NUM_SUBS; i++) begin
      adv[i] = '0;
      for (int p = 0; p < SUB_MAX; p++) begin
        for (int m = 0; m <= p; m++) begin
          if ((int'(prog[i]) == p) && (p < SUB_LEN[i]) && border(i, p, m) &&
              (sub_char(i, m) == cmd.data)) adv[i] = PROG_W'(m + 1);
        end
      end
    end
  end

  always_comb begin
    priority if (alive_class[EXACT_OK]) class_status = ST_OK;
    else if (alive_class[NUM_EXACT-1:1] != '0) class_status = ST_ERR;
    else if (found[SUB_WIFI_CONN]) class_status = ST_OK;
    else if (found[SUB_WIFI_DISC]) class_status = status;
    else if (found[SUB_CONNECT]) class_status = ST_OK;
    else if (found[SUB_CLOSED] || found[SUB_IPD]) class_status = status;
    else if (found[SUB_SEND_OK] || found[SUB_PROMPT]) class_status = ST_OK;
    else class_status = status;
  end

  always_comb begin
    priority if (cmd.arm) status_next = ST_WAIT;
    else if (do_class) status_next = class_status;
    else status_next = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status      <= ST_WAIT;
      line_length <= '0;
      zero_seen   <= 1'b0;
      alive       <= '1;
      found       <= '0;
      for (int i = 0; i < NUM_SUBS; i++) prog[i] <= '0;
    end else begin
      status <= status_next;
      if (do_class) begin
        line_length <= '0;
        zero_seen   <= 1'b0;
        alive       <= '1;
        found       <= '0;
        for (int i = 0; i < NUM_SUBS; i++) prog[i] <= '0;
      end else if (keep) begin
        line_length <= line_length + 1'b1;
        if (feed) begin
          alive <= alive_next;
          if (cmd.data == 8'h00) begin
            zero_seen <= 1'b1;
          end else begin
            for (int i = 0; i < NUM_SUBS; i++) begin
              if (!found[i]) begin
                if (int'(adv[i]) == SUB_LEN[i]) begin
                  found[i] <= 1'b1;
                  prog[i]  <= '0;
                end else begin
                  prog[i] <= adv[i];
                end
              end
            end
          end
        end
      end
    end
  end

endmodule

### rtl/core/at_reply_ring_and_line_classifier_top.sv
// top level: ring buffer around a registered-read ram, line classifier, output stage
// depends on arl_pkg, arl_in_if, arl_out_if, arl_ram, arl_line and the macros header
//
// in_ch carries one item per handshake: op 0 pushes rx_byte into the ring and
// feeds the line classifier, op 1 pops one ring byte, op 2 arms (status back to
// waiting), op 3 does nothing. every item gives exactly one result on out_ch.
// an accepted item passes the s1 stage, where the ring ram read happens, and then
// the output register before out_ch.valid. throughput is one item per cycle
// unless out_ch stalls; the ram read port and the ring pointers are touched at most
// once per item and the classifier state updates in the same cycle the item is taken.
// the ring holds up to RING_DEPTH-1 bytes; a byte that finds it full is flagged
// in byte_dropped and still goes to the classifier. lines keep at most
// LINE_LIMIT-1 bytes.
// reset (rst, synchronous) empties the ring, clears the line and sets the status
// to waiting; ram contents are not cleared and need no clearing pass.
// when out_ch.ready is low the output register and the one stage behind it
// hold, and in_ch.ready drops once both are full.
`include "at_reply_ring_and_line_classifier_top_macros.svh"
module at_reply_ring_and_line_classifier_top #(
  parameter int RING_DEPTH = 256,
  parameter int LINE_LIMIT = 128
) (
  input logic      clk,
  input logic      rst,
  arl_in_if.sink   in_ch,
  arl_out_if.source out_ch
);
  import arl_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] read_ptr;
  logic [PTR_W-1:0] write_ptr_inc;
  logic [PTR_W-1:0] read_ptr_inc;

  logic    accept;
  op_t     op_in;
  logic    is_rx;
  logic    is_pop;
  logic    full;
  logic    ram_we;
  logic    ram_re;
  logic [7:0] ram_rdata;

  line_cmd_t line_cmd;
  status_t   status_next;

  logic    s1_valid;
  logic    s1_pop_valid;
  logic    s1_dropped;
  status_t s1_response;
  logic    s1_move;

  logic       out_valid;
  logic       out_pop_valid;
  logic [7:0] out_pop_byte;
  logic [1:0] out_response;
  logic       out_dropped;

  assign s1_move     = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || s1_move;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op_in       = op_t'(in_ch.op);
  assign is_rx       = accept && (op_in == OP_RX);
  assign is_pop      = accept && (op_in == OP_POP);

  assign write_ptr_inc = (write_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : write_ptr + 1'b1;
  assign read_ptr_inc  = (read_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : read_ptr + 1'b1;
  assign full          = (write_ptr_inc == read_ptr);
  assign ram_we        = is_rx && !full;
  assign ram_re        = is_pop && (read_ptr != write_ptr);

  arl_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata (in_ch.rx_byte),
    .re    (ram_re),
    .raddr (read_ptr),
    .rdata (ram_rdata)
  );

  assign line_cmd.rx   = is_rx;
  assign line_cmd.arm  = accept && (op_in == OP_ARM);
  assign line_cmd.data = in_ch.rx_byte;

  arl_line #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_line (
    .clk         (clk),
    .rst         (rst),
    .cmd         (line_cmd),
    .status_next (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ram_we) write_ptr <= write_ptr_inc;
      if (ram_re) read_ptr <= read_ptr_inc;
      if (accept) s1_valid <= 1'b1;
      else if (s1_move) s1_valid <= 1'b0;
      if (s1_move) out_valid <= s1_valid;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop_valid <= ram_re;
      s1_dropped   <= is_rx && full;
      s1_response  <= status_next;
    end
    if (s1_move && s1_valid) begin
      out_pop_valid <= s1_pop_valid;
      out_pop_byte  <= s1_pop_valid ? ram_rdata : 8'h00;
      out_response  <= s1_response;
      out_dropped   <= s1_dropped;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.pop_valid    = out_pop_valid;
  assign out_ch.pop_byte     = out_pop_byte;
  assign out_ch.response     = out_response;
  assign out_ch.byte_dropped = out_dropped;

  `ARL_ASSERT(a_stall_blocks_input, s1_valid && out_valid && !out_ch.ready |-> !in_ch.ready, "input taken while both stages are stalled")
  `ARL_ASSERT(a_stage_holds, s1_valid && !s1_move |=> s1_valid, "held stage lost its item")
  `ARL_ASSERT(a_read_ptr_only_on_pop, !ram_re |=> $stable(read_ptr), "read pointer moved without a pop")
  `ARL_ASSERT_ALWAYS(a_pop_and_drop_exclusive, out_valid |-> !(out_pop_valid && out_dropped), "pop and drop flagged on one item")

endmodule
